// ===== rtl/core/value_noise_2d_cosine_macros.svh =====
// Assertion macros shared by the checker.
`ifndef VALUE_NOISE_2D_COSINE_MACROS_SVH
`define VALUE_NOISE_2D_COSINE_MACROS_SVH

// Property checked on the edge after the antecedent, without a reset guard.
`define VN2C_ASSERT_NEXT(lbl, clk, pre, post) \
   lbl: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("Assertion failed in the noise block.");

// Property checked on the edge after the antecedent, ignored during reset.
`define VN2C_ASSERT_NEXT_RST(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("Assertion failed in the noise block.");

`endif

// ===== rtl/core/vn2c_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vn2c_pkg;

   localparam int FRAC_BITS = 8;
   localparam int INT_BITS  = 20;
   localparam int COORD_W   = 28;
   localparam int CELL_W    = (INT_BITS + FRAC_BITS > COORD_W) ?
                              (COORD_W - FRAC_BITS) : INT_BITS;
   localparam int T16_SHIFT = 16 - FRAC_BITS;

   localparam int W_W    = 17;
   localparam int LAT_W  = 32;
   localparam int BLUR_W = 36;
   localparam int PROD_W = 54;
   localparam int SUM_W  = 55;
   localparam int OUT_W  = 16;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   localparam logic [31:0] HASH_Y_MUL  = 32'd2999;
   localparam logic [31:0] HASH_SQ_MUL = 32'd15731;
   localparam logic [31:0] HASH_ADD1   = 32'd792222;
   localparam logic [31:0] HASH_ADD2   = 32'd1376312589;
   localparam logic [31:0] HASH_MASK   = 32'h7fff_ffff;
   localparam logic [31:0] LAT_ONE     = 32'h4000_0000;

   localparam logic [W_W-1:0] COS_ROM [33] = '{
      17'd0,     17'd158,   17'd630,   17'd1411,  17'd2494,  17'd3869,
      17'd5522,  17'd7438,  17'd9598,  17'd11980, 17'd14563, 17'd17321,
      17'd20228, 17'd23256, 17'd26375, 17'd29556, 17'd32768, 17'd35980,
      17'd39161, 17'd42280, 17'd45308, 17'd48215, 17'd50973, 17'd53556,
      17'd55938, 17'd58098, 17'd60014, 17'd61667, 17'd63042, 17'd64125,
      17'd64906, 17'd65378, 17'd65536
   };

   typedef struct packed {
      logic [31:0]    cell_x;
      logic [31:0]    cell_y;
      logic [W_W-1:0] weight_x;
      logic [W_W-1:0] weight_y;
   } item_type;

   typedef struct packed {
      logic [W_W-1:0] weight_x;
      logic [W_W-1:0] weight_y;
   } weights_type;

   function automatic logic [W_W-1:0] cos_weight(input logic [FRAC_BITS-1:0] frac);
      logic [15:0]    t16;
      logic [5:0]     idx;
      logic [W_W-1:0] lo;
      logic [W_W-1:0] hi;
      logic [22:0]    prod;
      t16  = 16'(frac) << T16_SHIFT;
      idx  = {1'b0, t16[15:11]};
      lo   = COS_ROM[idx];
      hi   = COS_ROM[idx + 6'd1];
      prod = 23'(hi - lo) * 23'(t16[10:0]) + 23'd1024;
      return lo + W_W'(prod >> 11);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/vn2c_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vn2c_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [vn2c_pkg::COORD_W-1:0]  req_x_coord,
   input  logic [vn2c_pkg::COORD_W-1:0]  req_y_coord,
   output logic                          out_valid,
   input  logic                          out_ready,
   output vn2c_pkg::item_type            out_item
);
   import vn2c_pkg::*;

   logic     vld_ff;
   logic     vld_in;
   item_type item_ff;
   item_type item_in;
   logic     load;

   assign req_ready = !vld_ff || out_ready;
   assign load      = req_valid && req_ready;
   assign vld_in    = load || (vld_ff && !out_ready);

   always_comb begin
      item_in.cell_x   = 32'(req_x_coord[FRAC_BITS +: CELL_W]);
      item_in.cell_y   = 32'(req_y_coord[FRAC_BITS +: CELL_W]);
      item_in.weight_x = cos_weight(req_x_coord[FRAC_BITS-1:0]);
      item_in.weight_y = cos_weight(req_y_coord[FRAC_BITS-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_item  = item_ff;
endmodule
`default_nettype wire

// ===== rtl/core/vn2c_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vn2c_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  vn2c_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_pop,
   output vn2c_pkg::item_type out_item
);
   import vn2c_pkg::*;

   item_type          mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              push;
   logic              pop;

   assign in_ready  = (count_ff != QCNT_W'(QDEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;
   assign out_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/vn2c_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vn2c_hash (
   input  logic                                clock,
   input  logic                                en,
   input  logic [31:0]                         px,
   input  logic [31:0]                         py,
   output logic signed [vn2c_pkg::LAT_W-1:0]   lattice
);
   import vn2c_pkg::*;

   logic [31:0]             n0_ff;
   logic [31:0]             n1_ff;
   logic [31:0]             sq_ff;
   logic [31:0]             n2_ff;
   logic [31:0]             t_ff;
   logic signed [LAT_W-1:0] lat_ff;
   logic [31:0]             mixed;
   logic [31:0]             h;

   assign mixed = (n0_ff << 13) ^ n0_ff;
   assign h     = (n2_ff * t_ff + HASH_ADD2) & HASH_MASK;

   always_ff @(posedge clock) begin
      if (en) begin
         n0_ff  <= px + py * HASH_Y_MUL;
         n1_ff  <= mixed;
         sq_ff  <= mixed * mixed;
         n2_ff  <= n1_ff;
         t_ff   <= sq_ff * HASH_SQ_MUL + HASH_ADD1;
         lat_ff <= $signed(LAT_ONE) - $signed(h);
      end
   end

   assign lattice = lat_ff;
endmodule
`default_nettype wire

// ===== rtl/core/vn2c_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vn2c_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   output logic                                q_pop,
   input  vn2c_pkg::item_type                  q_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [vn2c_pkg::OUT_W-1:0]   rsp_noise_value
);
   import vn2c_pkg::*;

   localparam int LANE_STAGES = 4;

   logic                     en;
   logic                     vld_ff [8];
   weights_type              w_ff [6];
   logic signed [LAT_W-1:0]  lat [16];
   logic signed [BLUR_W-1:0] blur_in [4];
   logic signed [BLUR_W-1:0] blur_ff [4];
   logic signed [SUM_W-1:0]  sx_ff [2];
   logic signed [SUM_W-1:0]  sy_ff;
   logic signed [BLUR_W-1:0] ix [2];
   logic signed [BLUR_W-1:0] ry;
   logic signed [16:0]       q;
   logic signed [OUT_W-1:0]  out_ff;
   logic signed [OUT_W-1:0]  out_in;
   logic signed [17:0]       wx_lo;
   logic signed [17:0]       wx_hi;
   logic signed [17:0]       wy_lo;
   logic signed [17:0]       wy_hi;
   logic signed [PROD_W-1:0] p_a [2];
   logic signed [PROD_W-1:0] p_b [2];
   logic signed [PROD_W-1:0] p_c;
   logic signed [PROD_W-1:0] p_d;

   assign en    = !vld_ff[7] || rsp_ready;
   assign q_pop = en && q_valid;

   for (genvar j = 0; j < 4; j++) begin : g_row
      for (genvar k = 0; k < 4; k++) begin : g_col
         vn2c_hash u_hash (
            .clock   (clock),
            .en      (en),
            .px      (q_item.cell_x + 32'(k) - 32'd1),
            .py      (q_item.cell_y + 32'(j) - 32'd1),
            .lattice (lat[j*4+k])
         );
      end
   end

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         blur_in[c] = '0;
         for (int dj = 0; dj < 3; dj++) begin
            for (int dk = 0; dk < 3; dk++) begin
               blur_in[c] = blur_in[c] +
                  (BLUR_W'(lat[((c / 2) + dj) * 4 + (c % 2) + dk]) <<<
                   (((dj == 1) ? 1 : 0) + ((dk == 1) ? 1 : 0)));
            end
         end
      end
   end

   always_comb begin
      wx_hi  = $signed({1'b0, w_ff[LANE_STAGES].weight_x});
      wx_lo  = $signed({1'b0, W_W'(18'd65536 - 18'(w_ff[LANE_STAGES].weight_x))});
      wy_hi  = $signed({1'b0, w_ff[LANE_STAGES+1].weight_y});
      wy_lo  = $signed({1'b0, W_W'(18'd65536 - 18'(w_ff[LANE_STAGES+1].weight_y))});
      for (int r = 0; r < 2; r++) begin
         p_a[r] = blur_ff[2*r] * wx_lo;
         p_b[r] = blur_ff[2*r+1] * wx_hi;
         ix[r]  = BLUR_W'((sx_ff[r] + SUM_W'(32768)) >>> 16);
      end
      p_c    = ix[0] * wy_lo;
      p_d    = ix[1] * wy_hi;
      ry     = BLUR_W'((sy_ff + SUM_W'(32768)) >>> 16);
      q      = 17'((ry + BLUR_W'(262144)) >>> 19);
      if (q > 17'sd32767) begin
         out_in = 16'sh7fff;
      end else if (q < -17'sd32768) begin
         out_in = -16'sh8000;
      end else begin
         out_in = q[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 8; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= q_pop;
         for (int s = 1; s < 8; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff[0] <= '{weight_x: q_item.weight_x, weight_y: q_item.weight_y};
         for (int s = 1; s < 6; s++) begin
            w_ff[s] <= w_ff[s-1];
         end
         blur_ff <= blur_in;
         for (int r = 0; r < 2; r++) begin
            sx_ff[r] <= SUM_W'(p_a[r]) + SUM_W'(p_b[r]);
         end
         sy_ff  <= SUM_W'(p_c) + SUM_W'(p_d);
         out_ff <= out_in;
      end
   end

   assign rsp_valid       = vld_ff[7];
   assign rsp_noise_value = out_ff;
endmodule
`default_nettype wire

// ===== rtl/core/value_noise_2d_cosine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Two-dimensional value noise with a 3x3 lattice blur and cosine blending. The block
// takes one coordinate pair per clock and returns one Q1.15 sample per clock, in order,
// while the output is not stalled. An item passes the input register, a four-entry queue
// and the back pipeline: the registers of the sixteen parallel lattice hashes, whose four
// chained 32-bit multiplies set their depth, then the blur register, the blend registers
// for x and then y, and the output register that holds the rounded result. An output
// stall freezes the back pipeline and fills the queue.
module value_noise_2d_cosine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [vn2c_pkg::COORD_W-1:0]        req_x_coord,
   input  logic [vn2c_pkg::COORD_W-1:0]        req_y_coord,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [vn2c_pkg::OUT_W-1:0]   rsp_noise_value
);
   import vn2c_pkg::*;

   logic     f_valid;
   logic     f_ready;
   item_type f_item;
   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   vn2c_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_x_coord (req_x_coord),
      .req_y_coord (req_y_coord),
      .out_valid   (f_valid),
      .out_ready   (f_ready),
      .out_item    (f_item)
   );

   vn2c_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_item  (q_item)
   );

   vn2c_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_item          (q_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_noise_value (rsp_noise_value)
   );
endmodule
`default_nettype wire

// ===== rtl/core/vn2c_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "value_noise_2d_cosine_macros.svh"
module vn2c_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [vn2c_pkg::COORD_W-1:0]        req_x_coord,
   input logic [vn2c_pkg::COORD_W-1:0]        req_y_coord,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [vn2c_pkg::OUT_W-1:0]   rsp_noise_value
);
   logic unused_in;

   assign unused_in = req_valid ^ (^req_x_coord) ^ (^req_y_coord);

   `VN2C_ASSERT_NEXT(a_reset_no_rsp, clock, reset, !rsp_valid)
   `VN2C_ASSERT_NEXT(a_reset_ready, clock, reset, req_ready)
   `VN2C_ASSERT_NEXT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_noise_value))
endmodule

bind value_noise_2d_cosine vn2c_checker u_checker (.*);
`default_nettype wire
